// File: rtl/core/qhsc_pkg.sv
// Shared types, constants and step tables for the quintic Hermite coefficient block.
package qhsc_pkg;

    // Axis count is tied to the named per-axis ports of the top level
    localparam int AXES             = 3;
    localparam int AXW              = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int SAMPLE_WIDTH_DEF = 32;

    // Result field widths
    localparam int COEF_W = 64;
    localparam int DUR_W  = 32;
    localparam int IDX_W  = 3;
    localparam int ST_W   = 2;
    localparam int QUO_W  = 64;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK  = 2'd0;
    localparam logic [ST_W-1:0] ST_SAT = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD = 2'd2;

    // Coefficient indexes: c0..c2 come from the divider, c3..c5 are scaled samples
    localparam int              NUM_DIV  = 3;
    localparam logic [1:0]      CI_LDIV  = 2'd2;
    localparam logic [IDX_W-1:0] CI_ACC  = 3'd3;
    localparam logic [IDX_W-1:0] CI_VEL  = 3'd4;
    localparam logic [IDX_W-1:0] CI_POS  = 3'd5;

    // Saturation limits of a Q32.32 coefficient
    localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    // Depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Steps of the linear combination that forms each divided numerator
    localparam int LIN_STEPS = 5;
    localparam int LS_W      = 3;

    // Job control from front to back
    typedef struct packed {
        logic valid;
        logic bad;
    } t_jctl;

    typedef enum logic [1:0] {
        SRC_A    = 2'd0,
        SRC_B    = 2'd1,
        SRC_C    = 2'd2,
        SRC_NONE = 2'd3
    } t_src;

    typedef struct packed {
        t_src       src;
        logic [2:0] sh;
        logic       neg;
    } t_lin;

    // c0 = 6A - 3B + C, c1 = -15A + 7B - 2C, c2 = 10A - 4B + C, as shift-add terms
    function automatic t_lin lin_step(input logic [1:0] ci, input logic [LS_W-1:0] st);
        t_lin r;
        r = '{src: SRC_NONE, sh: 3'd0, neg: 1'b0};
        case (ci)
            2'd0: begin
                case (st)
                    3'd0:    r = '{src: SRC_A, sh: 3'd2, neg: 1'b0};
                    3'd1:    r = '{src: SRC_A, sh: 3'd1, neg: 1'b0};
                    3'd2:    r = '{src: SRC_B, sh: 3'd1, neg: 1'b1};
                    3'd3:    r = '{src: SRC_B, sh: 3'd0, neg: 1'b1};
                    3'd4:    r = '{src: SRC_C, sh: 3'd0, neg: 1'b0};
                    default: r = '{src: SRC_NONE, sh: 3'd0, neg: 1'b0};
                endcase
            end
            2'd1: begin
                case (st)
                    3'd0:    r = '{src: SRC_A, sh: 3'd4, neg: 1'b1};
                    3'd1:    r = '{src: SRC_A, sh: 3'd0, neg: 1'b0};
                    3'd2:    r = '{src: SRC_B, sh: 3'd3, neg: 1'b0};
                    3'd3:    r = '{src: SRC_B, sh: 3'd0, neg: 1'b1};
                    3'd4:    r = '{src: SRC_C, sh: 3'd1, neg: 1'b1};
                    default: r = '{src: SRC_NONE, sh: 3'd0, neg: 1'b0};
                endcase
            end
            2'd2: begin
                case (st)
                    3'd0:    r = '{src: SRC_A, sh: 3'd3, neg: 1'b0};
                    3'd1:    r = '{src: SRC_A, sh: 3'd1, neg: 1'b0};
                    3'd2:    r = '{src: SRC_B, sh: 3'd2, neg: 1'b1};
                    3'd3:    r = '{src: SRC_C, sh: 3'd0, neg: 1'b0};
                    default: r = '{src: SRC_NONE, sh: 3'd0, neg: 1'b0};
                endcase
            end
            default: r = '{src: SRC_NONE, sh: 3'd0, neg: 1'b0};
        endcase
        return r;
    endfunction

    // Right shift that turns the scaled numerator into the first divider remainder
    function automatic logic [5:0] div_shift(input logic [1:0] ci);
        logic [5:0] s;
        case (ci)
            2'd0:    s = 6'd1;
            2'd1:    s = 6'd17;
            default: s = 6'd33;
        endcase
        return s;
    endfunction

endpackage

// File: rtl/core/quintic_hermite_segment_coefficients.sv
// Quintic Hermite segment coefficients: top level joining front end, job queue and back end.
//
// Input channel: a knot (time, and position, velocity, acceleration per axis, Q16.16) is
// taken at a clock edge with push high and full low. Result channel: while empty is low the
// oldest result sits on the o_ ports and is taken at an edge with pop high.
// The first knot after reset is only stored. Each later knot yields six items, c0..c5,
// with Q32.32 coefficients per axis, the segment duration, a status and a last flag.
// Reset (synchronous, active low) forgets the stored knot and drops queued and pending work.
//
// Flow: a bad-interval segment goes straight to emission. A good segment first passes the
// shared bit-serial multiplier (powers of T and the per-axis A, B, C terms), then the
// combiner and restoring divider (a 64-bit quotient per coefficient and axis; the division
// is skipped when the quotient overflows), then rounding, and then its items are emitted.
// The back end works on one segment at a time. A two-entry job queue lets the front keep
// taking knots while the back works; full rises once both entries wait. When the receiver
// stalls, the output register holds its item and the back end waits at emission.
module quintic_hermite_segment_coefficients #(
    parameter int SAMPLE_WIDTH = qhsc_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [SAMPLE_WIDTH-1:0]             i_knot_time,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_pos_x,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_pos_y,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_pos_z,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_vel_x,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_vel_y,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_vel_z,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_acc_x,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_acc_y,
    input  logic signed [SAMPLE_WIDTH-1:0]      i_acc_z,
    output logic                                empty,
    input  logic                                pop,
    output logic [qhsc_pkg::IDX_W-1:0]          o_coef_index,
    output logic signed [qhsc_pkg::COEF_W-1:0]  o_coef_x,
    output logic signed [qhsc_pkg::COEF_W-1:0]  o_coef_y,
    output logic signed [qhsc_pkg::COEF_W-1:0]  o_coef_z,
    output logic [qhsc_pkg::DUR_W-1:0]          o_segment_duration,
    output logic [qhsc_pkg::ST_W-1:0]           o_status,
    output logic                                o_last_coef
);
    import qhsc_pkg::*;

    localparam int SW = SAMPLE_WIDTH;

    logic signed [SW-1:0]     pos [AXES];
    logic signed [SW-1:0]     vel [AXES];
    logic signed [SW-1:0]     acc [AXES];
    t_jctl                    jctl;
    logic                     job_pop;
    logic [SW-1:0]            tau;
    logic signed [SW-1:0]     p0 [AXES];
    logic signed [SW-1:0]     v0 [AXES];
    logic signed [SW-1:0]     a0 [AXES];
    logic signed [SW:0]       dp [AXES];
    logic signed [SW:0]       dv [AXES];
    logic signed [SW:0]       da [AXES];
    logic signed [COEF_W-1:0] coef [AXES];

    // Per-axis ports to arrays
    assign pos[0] = i_pos_x;
    assign pos[1] = i_pos_y;
    assign pos[2] = i_pos_z;
    assign vel[0] = i_vel_x;
    assign vel[1] = i_vel_y;
    assign vel[2] = i_vel_z;
    assign acc[0] = i_acc_x;
    assign acc[1] = i_acc_y;
    assign acc[2] = i_acc_z;

    qhsc_front #(.SW(SW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_time  (i_knot_time),
        .i_pos   (pos),
        .i_vel   (vel),
        .i_acc   (acc),
        .o_jctl  (jctl),
        .o_tau   (tau),
        .o_p0    (p0),
        .o_v0    (v0),
        .o_a0    (a0),
        .o_dp    (dp),
        .o_dv    (dv),
        .o_da    (da),
        .i_pop   (job_pop)
    );

    qhsc_back #(.SW(SW)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_jctl       (jctl),
        .i_tau        (tau),
        .i_p0         (p0),
        .i_v0         (v0),
        .i_a0         (a0),
        .i_dp         (dp),
        .i_dv         (dv),
        .i_da         (da),
        .o_job_pop    (job_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_coef_index (o_coef_index),
        .o_coef       (coef),
        .o_dur        (o_segment_duration),
        .o_status     (o_status),
        .o_last       (o_last_coef)
    );

    assign o_coef_x = coef[0];
    assign o_coef_y = coef[1];
    assign o_coef_z = coef[2];

endmodule

// File: rtl/core/qhsc_front.sv
// Front end: takes knots, keeps the previous one, classifies the segment and queues jobs.
module qhsc_front #(
    parameter int SW = qhsc_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic [SW-1:0]        i_time,
    input  logic signed [SW-1:0] i_pos [qhsc_pkg::AXES],
    input  logic signed [SW-1:0] i_vel [qhsc_pkg::AXES],
    input  logic signed [SW-1:0] i_acc [qhsc_pkg::AXES],
    output qhsc_pkg::t_jctl      o_jctl,
    output logic [SW-1:0]        o_tau,
    output logic signed [SW-1:0] o_p0 [qhsc_pkg::AXES],
    output logic signed [SW-1:0] o_v0 [qhsc_pkg::AXES],
    output logic signed [SW-1:0] o_a0 [qhsc_pkg::AXES],
    output logic signed [SW:0]   o_dp [qhsc_pkg::AXES],
    output logic signed [SW:0]   o_dv [qhsc_pkg::AXES],
    output logic signed [SW:0]   o_da [qhsc_pkg::AXES],
    input  logic                 i_pop
);
    import qhsc_pkg::*;

    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // Previous knot
    logic                 r_have;
    logic [SW-1:0]        r_ptime;
    logic signed [SW-1:0] r_ppos [AXES];
    logic signed [SW-1:0] r_pvel [AXES];
    logic signed [SW-1:0] r_pacc [AXES];

    // Job queue
    logic [QCW-1:0]       r_cnt;
    logic [QPW-1:0]       r_wp;
    logic [QPW-1:0]       r_rp;
    logic                 r_qbad [QUEUE_DEPTH];
    logic [SW-1:0]        r_qtau [QUEUE_DEPTH];
    logic signed [SW-1:0] r_qp0  [QUEUE_DEPTH][AXES];
    logic signed [SW-1:0] r_qv0  [QUEUE_DEPTH][AXES];
    logic signed [SW-1:0] r_qa0  [QUEUE_DEPTH][AXES];
    logic signed [SW:0]   r_qdp  [QUEUE_DEPTH][AXES];
    logic signed [SW:0]   r_qdv  [QUEUE_DEPTH][AXES];
    logic signed [SW:0]   r_qda  [QUEUE_DEPTH][AXES];

    logic accept;
    logic wr;
    logic rd;
    logic bad;

    assign o_full = (r_cnt == QCW'(QUEUE_DEPTH));
    assign accept = i_push && !o_full;
    assign wr     = accept && r_have;
    assign rd     = i_pop && (r_cnt != '0);
    assign bad    = (i_time <= r_ptime);

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_cnt  <= '0;
            r_wp   <= '0;
            r_rp   <= '0;
        end else begin
            if (accept) begin
                r_have <= 1'b1;
            end
            if (wr) begin
                r_wp <= (r_wp == QPW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= (r_rp == QPW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + QCW'(wr) - QCW'(rd);
        end
    end

    // Previous knot and queue payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ptime <= i_time;
            for (int a = 0; a < AXES; a++) begin
                r_ppos[a] <= i_pos[a];
                r_pvel[a] <= i_vel[a];
                r_pacc[a] <= i_acc[a];
            end
        end
        if (wr) begin
            r_qbad[r_wp] <= bad;
            r_qtau[r_wp] <= i_time - r_ptime;
            for (int a = 0; a < AXES; a++) begin
                r_qp0[r_wp][a] <= r_ppos[a];
                r_qv0[r_wp][a] <= r_pvel[a];
                r_qa0[r_wp][a] <= r_pacc[a];
                r_qdp[r_wp][a] <= (SW+1)'(i_pos[a]) - (SW+1)'(r_ppos[a]);
                r_qdv[r_wp][a] <= (SW+1)'(i_vel[a]) - (SW+1)'(r_pvel[a]);
                r_qda[r_wp][a] <= (SW+1)'(i_acc[a]) - (SW+1)'(r_pacc[a]);
            end
        end
    end

    // Head of queue
    assign o_jctl.valid = (r_cnt != '0);
    assign o_jctl.bad   = r_qbad[r_rp];
    assign o_tau        = r_qtau[r_rp];
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            o_p0[a] = r_qp0[r_rp][a];
            o_v0[a] = r_qv0[r_rp][a];
            o_a0[a] = r_qa0[r_rp][a];
            o_dp[a] = r_qdp[r_rp][a];
            o_dv[a] = r_qdv[r_rp][a];
            o_da[a] = r_qda[r_rp][a];
        end
    end

endmodule

// File: rtl/core/qhsc_back.sv
// Back end: shift-add multiplier, numerator combiner, restoring divider and result output.
module qhsc_back #(
    parameter int SW = qhsc_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  qhsc_pkg::t_jctl                      i_jctl,
    input  logic [SW-1:0]                        i_tau,
    input  logic signed [SW-1:0]                 i_p0 [qhsc_pkg::AXES],
    input  logic signed [SW-1:0]                 i_v0 [qhsc_pkg::AXES],
    input  logic signed [SW-1:0]                 i_a0 [qhsc_pkg::AXES],
    input  logic signed [SW:0]                   i_dp [qhsc_pkg::AXES],
    input  logic signed [SW:0]                   i_dv [qhsc_pkg::AXES],
    input  logic signed [SW:0]                   i_da [qhsc_pkg::AXES],
    output logic                                 o_job_pop,
    output logic                                 o_empty,
    input  logic                                 i_pop,
    output logic [qhsc_pkg::IDX_W-1:0]           o_coef_index,
    output logic signed [qhsc_pkg::COEF_W-1:0]   o_coef [qhsc_pkg::AXES],
    output logic [qhsc_pkg::DUR_W-1:0]           o_dur,
    output logic [qhsc_pkg::ST_W-1:0]            o_status,
    output logic                                 o_last
);
    import qhsc_pkg::*;

    localparam int HW = 3*SW + 4;   // A, B, C terms
    localparam int LW = 3*SW + 9;   // combined numerator
    localparam int DW = 5*SW;       // divisor, up to T^5
    localparam int MW = 5*SW + 1;   // multiplier accumulator
    localparam int RW = DW + 1;     // divider remainder
    localparam int CW = DW + 34;    // overflow compare
    localparam int BW = $clog2(SW);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL  = 8'b0000_0010,
        S_MFIN = 8'b0000_0100,
        S_LIN  = 8'b0000_1000,
        S_DCHK = 8'b0001_0000,
        S_DIV  = 8'b0010_0000,
        S_RND  = 8'b0100_0000,
        S_EMIT = 8'b1000_0000
    } t_state;

    typedef enum logic [3:0] {
        OP_T2, OP_T3, OP_T4, OP_T5, OP_AT, OP_AH, OP_BH, OP_DA, OP_CH
    } t_op;

    t_state r_state, n_state;
    logic   r_ov;

    // Job copy
    logic                 r_bad;
    logic [SW-1:0]        r_tau;
    logic signed [SW-1:0] r_p0 [AXES];
    logic signed [SW-1:0] r_v0 [AXES];
    logic signed [SW-1:0] r_a0 [AXES];
    logic signed [SW:0]   r_dp [AXES];
    logic signed [SW:0]   r_dv [AXES];
    logic signed [SW:0]   r_da [AXES];

    // Multiplier
    t_op                  r_op;
    logic signed [MW-1:0] r_mx;
    logic signed [MW-1:0] r_acc;
    logic [BW-1:0]        r_bit;
    logic [DW-1:0]        r_t3, r_t4, r_t5;
    logic signed [HW-1:0] r_at;
    logic signed [HW-1:0] r_ah [AXES];
    logic signed [HW-1:0] r_bh [AXES];
    logic signed [HW-1:0] r_ch [AXES];

    // Combiner and divider
    logic [AXW-1:0]       r_ax;
    logic [1:0]           r_ci;
    logic [LS_W-1:0]      r_ls;
    logic signed [LW-1:0] r_num;
    logic                 r_neg;
    logic                 r_ovf;
    logic [RW-1:0]        r_rem;
    logic [QUO_W-1:0]     r_low;
    logic [QUO_W-1:0]     r_q;
    logic [DW-1:0]        r_den;
    logic [5:0]           r_dc;
    logic [COEF_W-1:0]    r_cq [NUM_DIV][AXES];
    logic                 r_sat [NUM_DIV];
    logic [IDX_W-1:0]     r_ei;

    // Output register
    logic [IDX_W-1:0]         r_oidx;
    logic signed [COEF_W-1:0] r_ocoef [AXES];
    logic [DUR_W-1:0]         r_odur;
    logic [ST_W-1:0]          r_ost;
    logic                     r_olast;

    logic                 ax_last;
    logic [AXW-1:0]       ax_inc;
    logic                 out_load;
    t_lin                 lstep;
    logic signed [HW-1:0] lsrc;
    logic signed [LW-1:0] lterm;
    logic                 d_neg;
    logic [LW-1:0]        d_mag;
    logic [DW-1:0]        d_den;
    logic [5:0]           d_sh;
    logic                 d_ovf;
    logic [LW+QUO_W-1:0]  d_wide;
    logic [RW-1:0]        v_try;
    logic                 v_ge;
    logic                 rnd_up;
    logic [QUO_W:0]       rnd_q;
    logic                 rnd_sat;
    logic [COEF_W-1:0]    rnd_val;
    logic signed [COEF_W-1:0] e_coef [AXES];
    logic [ST_W-1:0]      e_st;

    assign ax_last   = (r_ax == AXW'(AXES - 1));
    assign ax_inc    = r_ax + 1'b1;
    assign out_load  = (r_state == S_EMIT) && (!r_ov || i_pop);
    assign o_job_pop = (r_state == S_IDLE) && i_jctl.valid;

    // Numerator term for the current combiner step
    always_comb begin
        lstep = lin_step(r_ci, r_ls);
        case (lstep.src)
            SRC_A:   lsrc = r_ah[r_ax];
            SRC_B:   lsrc = r_bh[r_ax];
            SRC_C:   lsrc = r_ch[r_ax];
            default: lsrc = '0;
        endcase
        lterm = LW'(lsrc) <<< lstep.sh;
    end

    // Divider setup: magnitude, divisor, overflow test and first remainder
    always_comb begin
        d_neg = r_num[LW-1];
        d_mag = d_neg ? (~r_num + 1'b1) : r_num;
        case (r_ci)
            2'd0:    d_den = r_t5;
            2'd1:    d_den = r_t4;
            default: d_den = r_t3;
        endcase
        d_sh   = div_shift(r_ci);
        d_ovf  = CW'(d_mag) >= (CW'(d_den) << d_sh);
        d_wide = {d_mag, {QUO_W{1'b0}}} >> d_sh;
    end

    // Divider step
    assign v_try = {r_rem[RW-2:0], r_low[QUO_W-1]};
    assign v_ge  = (v_try >= {1'b0, r_den});

    // Rounding and saturation
    always_comb begin
        rnd_up  = ({r_rem, 1'b0} >= {2'b00, r_den});
        rnd_q   = {1'b0, r_q} + (QUO_W+1)'(rnd_up);
        rnd_sat = r_ovf
               || (!r_neg && (rnd_q > (QUO_W+1)'(COEF_MAX)))
               || (r_neg && (rnd_q > (QUO_W+1)'(COEF_MIN)));
        if (rnd_sat) begin
            rnd_val = r_neg ? COEF_MIN : COEF_MAX;
        end else begin
            rnd_val = r_neg ? (~rnd_q[COEF_W-1:0] + 1'b1) : rnd_q[COEF_W-1:0];
        end
    end

    // Result fields for the current output index
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            if (r_bad) begin
                e_coef[a] = '0;
            end else if (r_ei < IDX_W'(NUM_DIV)) begin
                e_coef[a] = r_cq[r_ei[1:0]][a];
            end else if (r_ei == CI_ACC) begin
                e_coef[a] = COEF_W'(r_a0[a]) <<< 15;
            end else if (r_ei == CI_VEL) begin
                e_coef[a] = COEF_W'(r_v0[a]) <<< 16;
            end else begin
                e_coef[a] = COEF_W'(r_p0[a]) <<< 16;
            end
        end
        if (r_bad) begin
            e_st = ST_BAD;
        end else if ((r_ei < IDX_W'(NUM_DIV)) && r_sat[r_ei[1:0]]) begin
            e_st = ST_SAT;
        end else begin
            e_st = ST_OK;
        end
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_jctl.valid) n_state = i_jctl.bad ? S_EMIT : S_MUL;
            end
            S_MUL: begin
                if (r_bit == '0) n_state = S_MFIN;
            end
            S_MFIN: begin
                n_state = (r_op == OP_CH && ax_last) ? S_LIN : S_MUL;
            end
            S_LIN: begin
                if (r_ls == LS_W'(LIN_STEPS - 1)) n_state = S_DCHK;
            end
            S_DCHK: begin
                n_state = d_ovf ? S_RND : S_DIV;
            end
            S_DIV: begin
                if (r_dc == '1) n_state = S_RND;
            end
            S_RND: begin
                n_state = (ax_last && r_ci == CI_LDIV) ? S_EMIT : S_LIN;
            end
            S_EMIT: begin
                if (out_load && r_ei == CI_POS) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_jctl.valid) begin
                    r_bad <= i_jctl.bad;
                    r_tau <= i_tau;
                    for (int a = 0; a < AXES; a++) begin
                        r_p0[a] <= i_p0[a];
                        r_v0[a] <= i_v0[a];
                        r_a0[a] <= i_a0[a];
                        r_dp[a] <= i_dp[a];
                        r_dv[a] <= i_dv[a];
                        r_da[a] <= i_da[a];
                    end
                    for (int k = 0; k < NUM_DIV; k++) r_sat[k] <= 1'b0;
                    r_mx  <= MW'(i_tau);
                    r_acc <= '0;
                    r_bit <= BW'(SW - 1);
                    r_op  <= OP_T2;
                    r_ax  <= '0;
                    r_ci  <= '0;
                    r_ls  <= '0;
                    r_num <= '0;
                    r_ei  <= '0;
                end
            end
            // one multiplier bit per cycle, MSB first
            S_MUL: begin
                r_acc <= (r_acc <<< 1) + (r_tau[r_bit] ? r_mx : '0);
                r_bit <= r_bit - 1'b1;
            end
            // take the product and load the next operand
            S_MFIN: begin
                r_acc <= '0;
                r_bit <= BW'(SW - 1);
                case (r_op)
                    OP_T2: begin
                        r_mx <= r_acc;
                        r_op <= OP_T3;
                    end
                    OP_T3: begin
                        r_t3 <= DW'(r_acc);
                        r_mx <= r_acc;
                        r_op <= OP_T4;
                    end
                    OP_T4: begin
                        r_t4 <= DW'(r_acc);
                        r_mx <= r_acc;
                        r_op <= OP_T5;
                    end
                    OP_T5: begin
                        r_t5 <= DW'(r_acc);
                        r_mx <= MW'(r_a0[r_ax]);
                        r_op <= OP_AT;
                    end
                    OP_AT: begin
                        r_at <= HW'(r_acc);
                        r_mx <= (MW'(r_v0[r_ax]) <<< 17) + r_acc;
                        r_op <= OP_AH;
                    end
                    OP_AH: begin
                        r_ah[r_ax] <= HW'((MW'(r_dp[r_ax]) <<< 33) - r_acc);
                        r_mx <= (MW'(r_dv[r_ax]) <<< 17) - (MW'(r_at) <<< 1);
                        r_op <= OP_BH;
                    end
                    OP_BH: begin
                        r_bh[r_ax] <= HW'(r_acc);
                        r_mx <= MW'(r_da[r_ax]);
                        r_op <= OP_DA;
                    end
                    OP_DA: begin
                        r_mx <= r_acc;
                        r_op <= OP_CH;
                    end
                    OP_CH: begin
                        r_ch[r_ax] <= HW'(r_acc);
                        if (ax_last) begin
                            r_ax  <= '0;
                            r_ci  <= '0;
                            r_ls  <= '0;
                            r_num <= '0;
                        end else begin
                            r_ax <= ax_inc;
                            r_mx <= MW'(r_a0[ax_inc]);
                            r_op <= OP_AT;
                        end
                    end
                    default: r_op <= OP_T2;
                endcase
            end
            S_LIN: begin
                r_num <= lstep.neg ? (r_num - lterm) : (r_num + lterm);
                r_ls  <= r_ls + 1'b1;
            end
            S_DCHK: begin
                r_neg <= d_neg;
                r_ovf <= d_ovf;
                r_rem <= RW'(d_wide[LW+QUO_W-1:QUO_W]);
                r_low <= d_wide[QUO_W-1:0];
                r_den <= d_den;
                r_q   <= '0;
                r_dc  <= '0;
            end
            // restoring division, one quotient bit per cycle
            S_DIV: begin
                r_rem <= v_ge ? (v_try - {1'b0, r_den}) : v_try;
                r_q   <= {r_q[QUO_W-2:0], v_ge};
                r_low <= r_low << 1;
                r_dc  <= r_dc + 1'b1;
            end
            S_RND: begin
                r_cq[r_ci][r_ax] <= rnd_val;
                if (rnd_sat) r_sat[r_ci] <= 1'b1;
                r_ls  <= '0;
                r_num <= '0;
                if (ax_last) begin
                    r_ax <= '0;
                    r_ci <= r_ci + 1'b1;
                end else begin
                    r_ax <= ax_inc;
                end
            end
            S_EMIT: begin
                if (out_load) begin
                    r_oidx  <= r_ei;
                    for (int a = 0; a < AXES; a++) r_ocoef[a] <= e_coef[a];
                    r_odur  <= r_bad ? '0 : DUR_W'(r_tau);
                    r_ost   <= e_st;
                    r_olast <= (r_ei == CI_POS);
                    r_ei    <= r_ei + 1'b1;
                end
            end
            default: r_ei <= '0;
        endcase
    end

    assign o_empty      = !r_ov;
    assign o_coef_index = r_oidx;
    assign o_coef       = r_ocoef;
    assign o_dur        = r_odur;
    assign o_status     = r_ost;
    assign o_last       = r_olast;

endmodule

// File: test/testbench.sv
// Testbench for the quintic Hermite segment coefficient block: directed and random knots, checked results.
`timescale 1ns / 100ps

module testbench;
    import qhsc_pkg::*;

    localparam int SW = 32;
    localparam int WB = 352;
    localparam longint CYCLE_LIMIT = 4000000;

    typedef struct {
        logic [SW-1:0]        t;
        logic signed [SW-1:0] p[3];
        logic signed [SW-1:0] v[3];
        logic signed [SW-1:0] a[3];
    } t_knot;

    typedef struct {
        logic [IDX_W-1:0]  idx;
        logic [COEF_W-1:0] c[3];
        logic [DUR_W-1:0]  dur;
        logic [ST_W-1:0]   st;
        logic              last;
    } t_coef;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full, empty;
    t_knot cur_knot;
    logic [SW-1:0] i_knot_time = '0;
    logic signed [SW-1:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic signed [SW-1:0] i_vel_x = '0, i_vel_y = '0, i_vel_z = '0;
    logic signed [SW-1:0] i_acc_x = '0, i_acc_y = '0, i_acc_z = '0;
    logic [IDX_W-1:0] o_coef_index;
    logic signed [COEF_W-1:0] o_coef_x, o_coef_y, o_coef_z;
    logic [DUR_W-1:0] o_segment_duration;
    logic [ST_W-1:0] o_status;
    logic o_last_coef;

    quintic_hermite_segment_coefficients #(.SAMPLE_WIDTH(SW)) uut (.*);

    // Clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_knot pending_knots[$];
    t_coef expected_coefs[$];
    int accepted_knots = 0;
    int errors = 0;
    int hold_cycles = 0;
    bit hold_done = 0;
    longint cycles = 0;

    // Predictor state
    logic [SW-1:0]        last_time = '0;
    logic signed [SW-1:0] last_p[3], last_v[3], last_a[3];
    bit have_last = 0;

    // Append a knot to the stimulus queue
    function automatic void queue_knot(input t_knot k);
        pending_knots.insert(pending_knots.size(), k);
    endfunction

    // round(num * 2^k / den) to nearest, ties away from zero, saturated to 64 bits
    function automatic logic [63:0] round_div(input logic signed [WB-1:0] num, input int k,
                                              input logic [WB-1:0] den, inout bit sat);
        logic [WB-1:0] mag, q;
        bit neg;
        neg = num < 0;
        mag = neg ? -num : num;
        mag = mag << k;
        q = (mag * 2 + den) / (den * 2);
        if (!neg && q > 64'h7FFF_FFFF_FFFF_FFFF) begin
            sat = 1;
            return COEF_MAX;
        end
        if (neg && q > 64'h8000_0000_0000_0000) begin
            sat = 1;
            return COEF_MIN;
        end
        return neg ? -q[63:0] : q[63:0];
    endfunction

    // Expected coefficients of the segment closed by one knot
    task automatic predict_segment(input t_knot k);
        t_coef r[6];
        bit sat[6];
        logic signed [WB-1:0] tau, tau2, tau3, tau4, tau5, ah, bh, ch;
        logic signed [WB-1:0] p0, p1, v0, v1, a0, a1;
        logic signed [63:0] wide;
        bit bad;
        if (!have_last) begin
            have_last = 1;
        end else begin
            bad = k.t <= last_time;
            sat = '{default: 0};
            tau = $signed({{(WB-SW){1'b0}}, k.t - last_time});
            tau2 = tau * tau;
            tau3 = tau2 * tau;
            tau4 = tau3 * tau;
            tau5 = tau4 * tau;
            for (int ax = 0; ax < 3; ax++) begin
                for (int i = 0; i < 6; i++) r[i].c[ax] = '0;
                if (!bad) begin
                    p0 = last_p[ax]; p1 = k.p[ax];
                    v0 = last_v[ax]; v1 = k.v[ax];
                    a0 = last_a[ax]; a1 = k.a[ax];
                    ah = ((p1 - p0) <<< 33) - ((v0 * tau) <<< 17) - a0 * tau2;
                    bh = (((v1 - v0) * tau) <<< 17) - 2 * a0 * tau2;
                    ch = (a1 - a0) * tau2;
                    r[0].c[ax] = round_div(6 * ah - 3 * bh + ch, 63, tau5, sat[0]);
                    r[1].c[ax] = round_div(-15 * ah + 7 * bh - 2 * ch, 47, tau4, sat[1]);
                    r[2].c[ax] = round_div(10 * ah - 4 * bh + ch, 31, tau3, sat[2]);
                    wide = last_a[ax];
                    r[3].c[ax] = wide <<< 15;
                    wide = last_v[ax];
                    r[4].c[ax] = wide <<< 16;
                    wide = last_p[ax];
                    r[5].c[ax] = wide <<< 16;
                end
            end
            for (int i = 0; i < 6; i++) begin
                r[i].idx = IDX_W'(i);
                r[i].dur = bad ? '0 : k.t - last_time;
                r[i].st = bad ? ST_BAD : (sat[i] ? ST_SAT : ST_OK);
                r[i].last = (i == 5);
                expected_coefs.insert(expected_coefs.size(), r[i]);
            end
        end
        last_time = k.t;
        last_p = k.p;
        last_v = k.v;
        last_a = k.a;
    endtask

    // Idle odds by phase: sender 24 / receiver 73, then reversed, then none
    function automatic bit sender_idles();
        if (accepted_knots < 100) return $urandom_range(99) < 24;
        if (accepted_knots < 200) return $urandom_range(99) < 73;
        return 0;
    endfunction

    function automatic bit receiver_idles();
        if (accepted_knots < 100) return $urandom_range(99) < 73;
        if (accepted_knots < 200) return $urandom_range(99) < 24;
        return 0;
    endfunction

    // Driver: an item moves on push && !full
    always @(posedge i_clk) begin
        t_knot nk;
        bit next_push;
        if (i_rst_n) begin
            if (push && !full) begin
                predict_segment(cur_knot);
                accepted_knots++;
                void'(pending_knots.pop_front());
            end
            next_push = pending_knots.size() > 0 && (push ? !(push && !full) || !sender_idles()
                                                             : !sender_idles());
            if (push && full) next_push = 1;
            if (next_push && pending_knots.size() > 0) begin
                nk = pending_knots[0];
                cur_knot <= nk;
                i_knot_time <= nk.t;
                i_pos_x <= nk.p[0]; i_pos_y <= nk.p[1]; i_pos_z <= nk.p[2];
                i_vel_x <= nk.v[0]; i_vel_y <= nk.v[1]; i_vel_z <= nk.v[2];
                i_acc_x <= nk.a[0]; i_acc_y <= nk.a[1]; i_acc_z <= nk.a[2];
                push <= 1'b1;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Long receiver hold-off once, as the last phase begins
    always @(posedge i_clk) begin
        if (!hold_done && accepted_knots >= 200) begin
            hold_done <= 1;
            hold_cycles <= 6000;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    // Monitor: check each result item against the oldest expectation
    always @(posedge i_clk) begin
        t_coef e;
        logic [COEF_W-1:0] got[3];
        if (i_rst_n) begin
            if (pop && !empty) begin
                got = '{o_coef_x, o_coef_y, o_coef_z};
                if (expected_coefs.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected item, index %0d", $realtime, o_coef_index);
                end else begin
                    e = expected_coefs.pop_front();
                    if (o_coef_index !== e.idx) begin
                        errors++;
                        $display("%0t: index exp %0d got %0d", $realtime, e.idx, o_coef_index);
                    end
                    for (int ax = 0; ax < 3; ax++)
                        if (got[ax] !== e.c[ax]) begin
                            errors++;
                            $display("%0t: c%0d axis %0d exp %h got %h", $realtime, e.idx, ax,
                                     e.c[ax], got[ax]);
                        end
                    if (o_segment_duration !== e.dur) begin
                        errors++;
                        $display("%0t: duration exp %h got %h", $realtime, e.dur,
                                 o_segment_duration);
                    end
                    if (o_status !== e.st) begin
                        errors++;
                        $display("%0t: c%0d status exp %0d got %0d", $realtime, e.idx, e.st,
                                 o_status);
                    end
                    if (o_last_coef !== e.last) begin
                        errors++;
                        $display("%0t: last exp %b got %b", $realtime, e.last, o_last_coef);
                    end
                end
            end
            pop <= (hold_cycles == 0) && !receiver_idles();
        end
    end

    // Timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic t_knot rand_knot(input logic [SW-1:0] t);
        t_knot k;
        k.t = t;
        for (int ax = 0; ax < 3; ax++) begin
            k.p[ax] = $urandom;
            k.v[ax] = $urandom;
            k.a[ax] = $urandom;
        end
        return k;
    endfunction

    // Knot with modest, trajectory-like samples
    function automatic t_knot tame_knot(input logic [SW-1:0] t);
        t_knot k;
        k.t = t;
        for (int ax = 0; ax < 3; ax++) begin
            k.p[ax] = $signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
            k.v[ax] = $signed($urandom_range(32'h000F_FFFF)) - 32'sh0008_0000;
            k.a[ax] = $signed($urandom_range(32'h000F_FFFF)) - 32'sh0008_0000;
        end
        return k;
    endfunction

    function automatic t_knot flat_knot(input logic [SW-1:0] t, input logic signed [SW-1:0] val);
        t_knot k;
        k.t = t;
        k.p = '{val, val, val};
        k.v = '{val, val, val};
        k.a = '{val, val, val};
        return k;
    endfunction

    // Stimulus
    initial begin
        logic [SW-1:0] now;
        int sel;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: first knot only stored, then extremes and special cases
        queue_knot(flat_knot(32'd0, 32'sh7FFF_FFFF));
        queue_knot(flat_knot(32'd1, -32'sh8000_0000));
        queue_knot(flat_knot(32'd2, 32'sh7FFF_FFFF));
        queue_knot(flat_knot(32'd2, 32'sd0));
        queue_knot(flat_knot(32'd1, 32'sd1));
        queue_knot(flat_knot(32'hFFFF_FFFF, -32'sd1));
        queue_knot(flat_knot(32'd0, 32'sd0));
        queue_knot(flat_knot(32'hFFFF_FFFF, 32'sh7FFF_FFFF));
        queue_knot(flat_knot(32'hFFFF_FFFF, 32'sd0));
        queue_knot(flat_knot(32'h0001_0000, 32'sd0));
        queue_knot(flat_knot(32'h0002_0000, 32'sh0001_0000));
        queue_knot(tame_knot(32'h0002_8000));
        queue_knot(rand_knot(32'h0002_8001));
        queue_knot(rand_knot(32'h8000_0000));
        queue_knot(tame_knot(32'h8000_0010));
        queue_knot(tame_knot(32'h8001_0010));

        // Random: mostly forward trajectories, some backward steps and raw noise
        now = 32'h8001_0010;
        for (int n = 0; n < 300; n++) begin
            sel = $urandom_range(99);
            if (sel < 8) begin
                now = $urandom;
                queue_knot(rand_knot(now));
            end else if (sel < 15) begin
                now = now - $urandom_range(3);
                queue_knot(tame_knot(now));
            end else if (sel < 30) begin
                now = now + $urandom_range(32'h0000_0FFF, 1);
                queue_knot(rand_knot(now));
            end else begin
                if (now > 32'hF000_0000) now = $urandom_range(32'h00FF_FFFF);
                now = now + $urandom_range(32'h0004_0000, 32'h0000_0100);
                queue_knot(tame_knot(now));
            end
        end

        while (pending_knots.size() != 0 || expected_coefs.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
        if (errors == 0 && expected_coefs.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
